### rtl/bit_manipulation_alu_core_macros.svh
// Assertion macros for the bit manipulation ALU core.
`ifndef BIT_MANIPULATION_ALU_CORE_MACROS_SVH
`define BIT_MANIPULATION_ALU_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define BMALU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmalu same-cycle check failed");

`define BMALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmalu next-cycle check failed");

`else

`define BMALU_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define BMALU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/bmalu_pkg.sv
// Shared types and constants for the bit manipulation ALU.
package bmalu_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned BYTE_W  = 8;

    typedef enum logic [3:0] {
        ACT_ANDN    = 4'd0,
        ACT_BLSI    = 4'd1,
        ACT_BLSMSK  = 4'd2,
        ACT_BLSR    = 4'd3,
        ACT_BEXTR   = 4'd4,
        ACT_BZHI    = 4'd5,
        ACT_TZCNT   = 4'd6,
        ACT_LZCNT   = 4'd7,
        ACT_RORX    = 4'd8,
        ACT_SARX    = 4'd9,
        ACT_SHLX    = 4'd10,
        ACT_SHRX    = 4'd11,
        ACT_PDEP    = 4'd12,
        ACT_PEXT    = 4'd13,
        ACT_EXTRACT = 4'd14,
        ACT_INSERT  = 4'd15
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [DATA_W-1:0]   operand_a;
        logic [DATA_W-1:0]   operand_b;
        logic                wide_size;
        logic [BYTE_W-1:0]   field_length;
        logic [BYTE_W-1:0]   field_index;
    } t_item;

endpackage

### rtl/bmalu_pdx.sv
// Parallel bit deposit and bit extract built on a prefix count of the mask.
module bmalu_pdx (
    input  logic [bmalu_pkg::DATA_W-1:0] i_src,
    input  logic [bmalu_pkg::DATA_W-1:0] i_mask,
    output logic [bmalu_pkg::DATA_W-1:0] o_dep,
    output logic [bmalu_pkg::DATA_W-1:0] o_ext
);

    localparam int unsigned W      = bmalu_pkg::DATA_W;
    localparam int unsigned LEVELS = bmalu_pkg::POS_W;

    logic [bmalu_pkg::CNT_W-1:0] sums [LEVELS+1][W];
    logic [bmalu_pkg::POS_W-1:0] rank [W];

    always_comb begin
        for (int i = 0; i < W; i++) begin
            sums[0][i] = bmalu_pkg::CNT_W'(i_mask[i]);
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < W; i++) begin
                if (i >= (1 << l)) begin
                    sums[l+1][i] = sums[l][i] + sums[l][i - (1 << l)];
                end else begin
                    sums[l+1][i] = sums[l][i];
                end
            end
        end
        rank[0] = '0;
        for (int i = 1; i < W; i++) begin
            rank[i] = sums[LEVELS][i-1][bmalu_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        o_dep = '0;
        o_ext = '0;
        for (int i = 0; i < W; i++) begin
            o_dep[i] = i_mask[i] & i_src[rank[i]];
        end
        for (int k = 0; k < W; k++) begin
            for (int i = 0; i < W; i++) begin
                if (i_mask[i] && i_src[i] && (rank[i] == bmalu_pkg::POS_W'(k))) begin
                    o_ext[k] = 1'b1;
                end
            end
        end
    end

endmodule

### rtl/bmalu_exec.sv
// Operation datapath: computes the result word for one registered item.
module bmalu_exec (
    input  bmalu_pkg::t_item             i_item,
    output logic [bmalu_pkg::DATA_W-1:0] o_result
);

    localparam int unsigned W  = bmalu_pkg::DATA_W;
    localparam int unsigned H  = bmalu_pkg::HALF_W;
    localparam int unsigned CW = bmalu_pkg::CNT_W;
    localparam int unsigned PW = bmalu_pkg::POS_W;
    localparam int unsigned BW = bmalu_pkg::BYTE_W;

    function automatic logic [CW-1:0] low_index(input logic [W-1:0] v);
        logic [W-1:0]  iso;
        logic [CW-1:0] n;
        iso = v & (~v + W'(1));
        n   = '0;
        for (int i = 0; i < W; i++) begin
            if (iso[i]) begin
                n = n | CW'(i);
            end
        end
        return n;
    endfunction

    logic [W-1:0]    a, b, sm, x, xm1, mb;
    logic [CW-1:0]   size;
    logic [PW-1:0]   sh;
    logic [W-1:0]    rev;
    logic [2*W-1:0]  rot_src, rot_out;
    logic [W-1:0]    sext;
    logic [BW-1:0]   bx_start, bx_len, bz_n;
    logic [W-1:0]    bx_mask;
    logic [PW-1:0]   f_len, f_idx;
    logic [CW-1:0]   f_end;
    logic            f_ok;
    logic [W-1:0]    f_mask;
    logic [W-1:0]    dep, ext;
    logic [W-1:0]    r;

    bmalu_pdx u_pdx (
        .i_src  (x),
        .i_mask (mb),
        .o_dep  (dep),
        .o_ext  (ext)
    );

    always_comb begin
        a     = i_item.operand_a;
        b     = i_item.operand_b;
        sm    = i_item.wide_size ? '1 : {{(W-H){1'b0}}, {H{1'b1}}};
        size  = i_item.wide_size ? CW'(W) : CW'(H);
        x     = a & sm;
        mb    = b & sm;
        xm1   = x - W'(1);
        sh    = i_item.wide_size ? b[PW-1:0] : {1'b0, b[PW-2:0]};

        for (int i = 0; i < W; i++) begin
            rev[i] = i_item.wide_size ? x[W-1-i] : ((i < H) ? x[H-1-i] : 1'b0);
        end

        rot_src = i_item.wide_size ? {x, x} : {{W{1'b0}}, x[H-1:0], x[H-1:0]};
        rot_out = rot_src >> sh;
        sext    = i_item.wide_size ? x : {{(W-H){x[H-1]}}, x[H-1:0]};

        bx_start = b[BW-1:0];
        bx_len   = b[2*BW-1:BW];
        bx_mask  = (bx_len[BW-1:PW] != '0) ? '1 : ~({W{1'b1}} << bx_len[PW-1:0]);
        bz_n     = b[BW-1:0];

        f_len  = i_item.field_length[PW-1:0];
        f_idx  = i_item.field_index[PW-1:0];
        f_end  = CW'(f_len) + CW'(f_idx);
        f_ok   = (f_len == '0) ? (f_idx == '0) : (f_end <= CW'(W));
        f_mask = ~({W{1'b1}} << f_len);

        r = '0;
        case (i_item.action)
            bmalu_pkg::ACT_ANDN:   r = (~a & b) & sm;
            bmalu_pkg::ACT_BLSI:   r = ((~x + W'(1)) & x) & sm;
            bmalu_pkg::ACT_BLSMSK: r = (xm1 ^ x) & sm;
            bmalu_pkg::ACT_BLSR:   r = xm1 & x;
            bmalu_pkg::ACT_BEXTR: begin
                if (CW'(bx_start) >= size || bx_start[BW-1:CW] != '0) begin
                    r = '0;
                end else begin
                    r = (x >> bx_start[PW-1:0]) & bx_mask;
                end
            end
            bmalu_pkg::ACT_BZHI: begin
                if (CW'(bz_n) >= size || bz_n[BW-1:CW] != '0) begin
                    r = x;
                end else begin
                    r = x & ~({W{1'b1}} << bz_n[PW-1:0]);
                end
            end
            bmalu_pkg::ACT_TZCNT:  r = (x == '0) ? W'(size) : W'(low_index(x));
            bmalu_pkg::ACT_LZCNT:  r = (x == '0) ? W'(size) : W'(low_index(rev));
            bmalu_pkg::ACT_RORX:   r = rot_out[W-1:0] & sm;
            bmalu_pkg::ACT_SARX:   r = W'($signed(sext) >>> sh) & sm;
            bmalu_pkg::ACT_SHLX:   r = (x << sh) & sm;
            bmalu_pkg::ACT_SHRX:   r = x >> sh;
            bmalu_pkg::ACT_PDEP:   r = dep;
            bmalu_pkg::ACT_PEXT:   r = ext;
            bmalu_pkg::ACT_EXTRACT: begin
                if (!f_ok) begin
                    r = '0;
                end else if (f_len == '0) begin
                    r = a;
                end else begin
                    r = (a >> f_idx) & f_mask;
                end
            end
            bmalu_pkg::ACT_INSERT: begin
                if (!f_ok) begin
                    r = a;
                end else if (f_len == '0) begin
                    r = b;
                end else begin
                    r = (a & ~(f_mask << f_idx)) | ((b & f_mask) << f_idx);
                end
            end
            default: r = '0;
        endcase
        o_result = r;
    end

endmodule

### rtl/bit_manipulation_alu_core.sv
// Top level of the bit manipulation ALU: input register, datapath, result register.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+----------------------------------------------
//  item in | i_valid | o_ready | i_action, i_operand_a, i_operand_b,
//          |         |         | i_wide_size, i_field_length, i_field_index
//  result  | o_valid | i_ready | o_result
//
//  One word per cycle sustained while i_ready holds; an accepted word passes through the
//  input register and then the result register before o_valid rises for it.
//  Synchronous active-low reset clears both stage valid flags; no clearing pass.
//  A stalled result holds in the result register; the input register takes a word
//  when it is empty or when the datapath can advance into the result register.
module bit_manipulation_alu_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [3:0]                   i_action,
    input  logic [bmalu_pkg::DATA_W-1:0] i_operand_a,
    input  logic [bmalu_pkg::DATA_W-1:0] i_operand_b,
    input  logic                         i_wide_size,
    input  logic [bmalu_pkg::BYTE_W-1:0] i_field_length,
    input  logic [bmalu_pkg::BYTE_W-1:0] i_field_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bmalu_pkg::DATA_W-1:0] o_result
);

    `include "bit_manipulation_alu_core_macros.svh"

    logic                         r_in_valid, n_in_valid;
    logic                         r_out_valid, n_out_valid;
    bmalu_pkg::t_item             r_item;
    logic [bmalu_pkg::DATA_W-1:0] r_result;
    logic [bmalu_pkg::DATA_W-1:0] exec_result;
    logic                         advance;
    logic                         in_acc;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        n_in_valid  = in_acc || (r_in_valid && !advance);
        n_out_valid = advance ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.action       <= bmalu_pkg::t_action'(i_action);
            r_item.operand_a    <= i_operand_a;
            r_item.operand_b    <= i_operand_b;
            r_item.wide_size    <= i_wide_size;
            r_item.field_length <= i_field_length;
            r_item.field_index  <= i_field_index;
        end
        if (advance && r_in_valid) begin
            r_result <= exec_result;
        end
    end

    bmalu_exec u_exec (
        .i_item   (r_item),
        .o_result (exec_result)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    `BMALU_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, in_acc, r_in_valid)
    `BMALU_ASSERT_NEXT(a_advance_fills, i_clk, i_rst_n, r_in_valid && advance, r_out_valid)
    `BMALU_ASSERT_SAME(a_full_blocks, i_clk, i_rst_n, r_in_valid && r_out_valid && !i_ready, !o_ready)

endmodule
